// File: hw/rtl/dsf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dsf_pkg
// Types, register indexes and helpers for the damped spring follow step unit.
// ----------------------------------------------------------------------------
package dsf_pkg;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIFF,
      ST_SQ,
      ST_SQRT,
      ST_MAG,
      ST_FMUL,
      ST_FDIV,
      ST_DAMP,
      ST_POS,
      ST_VEL,
      ST_DONE,
      ST_KSQRT
   } state_type;

   localparam logic [1:0]  REG_SPRING = 2'd0;
   localparam logic [1:0]  REG_REST   = 2'd1;
   localparam logic [23:0] K_RESET    = 24'h010000;
   localparam logic signed [31:0] DAMP_RESET = 32'sh0002_0000;
   localparam logic [63:0] SQRT_BIT0  = 64'h4000_0000_0000_0000;

   function automatic logic signed [31:0] sat32(input logic signed [67:0] x);
      logic signed [31:0] r;
      if (x > 68'sd2147483647) begin
         r = 32'sh7FFF_FFFF;
      end else if (x < -68'sd2147483648) begin
         r = 32'sh8000_0000;
      end else begin
         r = x[31:0];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// File: hw/rtl/damped_spring_follow_step_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// damped_spring_follow_step_unit
// One explicit Euler step of a damped spring follower per request, Q16.16.
// ----------------------------------------------------------------------------
// channel   direction  contents
// req_*     in         target x, y, z and time step
// rsp_*     out        new follower position x, y, z
// csr_*     in         register index and write data
//
// an item runs the differences, the squared length, the square root of it and
// the spring magnitude, then per axis the force product, its division by the
// length and the damping term, then position and velocity; a new request is
// taken after the result; a spring constant write runs the sqrt before ready.
// reset is synchronous; a waiting result holds while rsp_tready is low and
// the next item may run meanwhile, stopping only at the result register.
module damped_spring_follow_step_unit
   import dsf_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   // target_x[31:0], target_y[63:32], target_z[95:64], time_step[112:96], zero pad
   input  wire logic [119:0]  req_tdata,
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   // pos_x[31:0], pos_y[63:32], pos_z[95:64]
   output logic [95:0]        rsp_tdata,
   input  wire logic          csr_valid,
   output logic               csr_ready,
   input  wire logic [1:0]    csr_index,
   input  wire logic [31:0]   csr_data
);

   state_type state_ff, state_in;
   logic [1:0]  ax_ff, ax_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [23:0] k_ff, k_in;
   logic [30:0] rest_ff, rest_in;
   logic signed [31:0] damp_ff, damp_in;
   logic signed [31:0] last_ff [3];
   logic signed [31:0] last_in [3];
   logic signed [31:0] vel_ff [3];
   logic signed [31:0] vel_in [3];
   logic signed [31:0] tgt_ff [3];
   logic signed [31:0] tgt_in [3];
   logic signed [31:0] d_ff [3];
   logic signed [31:0] d_in [3];
   logic signed [31:0] acc_ff [3];
   logic signed [31:0] acc_in [3];
   logic signed [31:0] pos_ff [3];
   logic signed [31:0] pos_in [3];
   logic [16:0] dt_ff, dt_in;
   logic [63:0] sum_ff, sum_in;
   logic [31:0] len_ff, len_in;
   logic signed [31:0] mag_ff, mag_in;
   logic [63:0] sqn_ff, sqn_in, res_ff, res_in, bit_ff, bit_in;
   logic [32:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic        neg_ff, neg_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [95:0] rsp_data_ff, rsp_data_in;

   logic signed [33:0] mul_a, mul_b;
   logic signed [67:0] mul_p;
   logic [63:0] sq_t;
   logic [32:0] dv_t;
   logic [63:0] abs_p;
   logic signed [32:0] diff_t;
   logic signed [33:0] rl_t;

   assign mul_p = mul_a * mul_b;
   assign sq_t  = res_ff + bit_ff;
   assign dv_t  = {rem_ff[31:0], quo_ff[31]};
   assign abs_p = mul_p[67] ? 64'(-mul_p) : mul_p[63:0];
   assign rl_t  = $signed({3'b000, rest_ff}) - $signed({2'b00, len_ff});

   assign req_tready = (state_ff == ST_IDLE) && !csr_valid;
   assign csr_ready  = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_SQ: begin
            mul_a = 34'(d_ff[ax_ff]);
            mul_b = 34'(d_ff[ax_ff]);
         end
         ST_MAG: begin
            mul_a = rl_t;
            mul_b = $signed({10'b0, k_ff});
         end
         ST_FMUL: begin
            mul_a = 34'(d_ff[ax_ff]);
            mul_b = 34'(mag_ff);
         end
         ST_DAMP: begin
            mul_a = 34'(damp_ff);
            mul_b = 34'(vel_ff[ax_ff]);
         end
         ST_POS: begin
            mul_a = 34'(vel_ff[ax_ff]);
            mul_b = $signed({17'b0, dt_ff});
         end
         ST_VEL: begin
            mul_a = 34'(acc_ff[ax_ff]);
            mul_b = $signed({17'b0, dt_ff});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      ax_in        = ax_ff;
      cnt_in       = cnt_ff;
      k_in         = k_ff;
      rest_in      = rest_ff;
      damp_in      = damp_ff;
      last_in      = last_ff;
      vel_in       = vel_ff;
      tgt_in       = tgt_ff;
      d_in         = d_ff;
      acc_in       = acc_ff;
      pos_in       = pos_ff;
      dt_in        = dt_ff;
      sum_in       = sum_ff;
      len_in       = len_ff;
      mag_in       = mag_ff;
      sqn_in       = sqn_ff;
      res_in       = res_ff;
      bit_in       = bit_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      neg_in       = neg_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      diff_t       = '0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (csr_valid) begin
               if (csr_index == REG_SPRING) begin
                  k_in     = csr_data[23:0];
                  sqn_in   = {24'b0, csr_data[23:0], 16'b0};
                  res_in   = '0;
                  bit_in   = SQRT_BIT0;
                  cnt_in   = '0;
                  state_in = ST_KSQRT;
               end else if (csr_index == REG_REST) begin
                  rest_in = csr_data[30:0];
               end
            end else if (req_tvalid) begin
               tgt_in[0] = req_tdata[31:0];
               tgt_in[1] = req_tdata[63:32];
               tgt_in[2] = req_tdata[95:64];
               dt_in     = req_tdata[112:96];
               state_in  = ST_DIFF;
            end
         end
         ST_DIFF: begin
            for (int i = 0; i < 3; i++) begin
               diff_t  = {last_ff[i][31], last_ff[i]} - {tgt_ff[i][31], tgt_ff[i]};
               d_in[i] = sat32({{35{diff_t[32]}}, diff_t});
            end
            sum_in   = '0;
            ax_in    = '0;
            state_in = ST_SQ;
         end
         ST_SQ: begin
            sum_in = sum_ff + mul_p[63:0];
            if (ax_ff == 2'd2) begin
               sqn_in   = sum_ff + mul_p[63:0];
               res_in   = '0;
               bit_in   = SQRT_BIT0;
               cnt_in   = '0;
               state_in = ST_SQRT;
            end else begin
               ax_in = ax_ff + 2'd1;
            end
         end
         ST_SQRT, ST_KSQRT: begin
            if (sqn_ff >= sq_t) begin
               sqn_in = sqn_ff - sq_t;
               res_in = (res_ff >> 1) + bit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               if (state_ff == ST_KSQRT) begin
                  damp_in  = 32'(res_in[30:0]) <<< 1;
                  state_in = ST_IDLE;
               end else begin
                  len_in   = res_in[31:0];
                  state_in = ST_MAG;
               end
            end
         end
         ST_MAG: begin
            mag_in   = sat32(mul_p >>> 16);
            ax_in    = '0;
            state_in = ST_FMUL;
         end
         ST_FMUL: begin
            neg_in = mul_p[67];
            rem_in = {1'b0, abs_p[63:32]};
            quo_in = abs_p[31:0];
            cnt_in = '0;
            if (len_ff == 32'd0) begin
               rem_in   = '0;
               quo_in   = '0;
               neg_in   = 1'b0;
               state_in = ST_DAMP;
            end else begin
               state_in = ST_FDIV;
            end
         end
         ST_FDIV: begin
            if (dv_t >= {1'b0, len_ff}) begin
               rem_in = dv_t - {1'b0, len_ff};
               quo_in = {quo_ff[30:0], 1'b1};
            end else begin
               rem_in = dv_t;
               quo_in = {quo_ff[30:0], 1'b0};
            end
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               state_in = ST_DAMP;
            end
         end
         ST_DAMP: begin
            acc_in[ax_ff] = sat32(
               (neg_ff ? -$signed({36'b0, quo_ff}) : $signed({36'b0, quo_ff}))
               - (mul_p >>> 16));
            if (ax_ff == 2'd2) begin
               ax_in    = '0;
               state_in = ST_POS;
            end else begin
               ax_in    = ax_ff + 2'd1;
               state_in = ST_FMUL;
            end
         end
         ST_POS: begin
            pos_in[ax_ff] = sat32(68'(last_ff[ax_ff]) + (mul_p >>> 16));
            if (ax_ff == 2'd2) begin
               ax_in    = '0;
               state_in = ST_VEL;
            end else begin
               ax_in = ax_ff + 2'd1;
            end
         end
         ST_VEL: begin
            vel_in[ax_ff] = sat32(68'(vel_ff[ax_ff]) + (mul_p >>> 16));
            if (ax_ff == 2'd2) begin
               ax_in    = '0;
               state_in = ST_DONE;
            end else begin
               ax_in = ax_ff + 2'd1;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {pos_ff[2], pos_ff[1], pos_ff[0]};
               last_in      = pos_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ax_ff        <= '0;
         cnt_ff       <= '0;
         k_ff         <= K_RESET;
         rest_ff      <= '0;
         damp_ff      <= DAMP_RESET;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            last_ff[i] <= '0;
            vel_ff[i]  <= '0;
         end
      end else begin
         state_ff     <= state_in;
         ax_ff        <= ax_in;
         cnt_ff       <= cnt_in;
         k_ff         <= k_in;
         rest_ff      <= rest_in;
         damp_ff      <= damp_in;
         rsp_valid_ff <= rsp_valid_in;
         last_ff      <= last_in;
         vel_ff       <= vel_in;
      end
   end

   always_ff @(posedge clock) begin
      tgt_ff      <= tgt_in;
      d_ff        <= d_in;
      acc_ff      <= acc_in;
      pos_ff      <= pos_in;
      dt_ff       <= dt_in;
      sum_ff      <= sum_in;
      len_ff      <= len_in;
      mag_ff      <= mag_in;
      sqn_ff      <= sqn_in;
      res_ff      <= res_in;
      bit_ff      <= bit_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      neg_ff      <= neg_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule
`default_nettype wire
